// File: src/pfba_pkg.sv
// ----------------------------------------------------------------------------
// pfba_pkg
// Shared types, constants and helpers of the page frame bitmap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package pfba_pkg;

    localparam int CFG_W         = 13;
    localparam int ADDR_W        = 24;
    localparam int MAX_PAGES_DEF = 4096;
    localparam int FRAME_BYTES   = 4096;
    localparam int FRAME_SHIFT   = $clog2(FRAME_BYTES);
    localparam int PFN_W         = ADDR_W - FRAME_SHIFT;

    localparam logic [CFG_W-1:0] INSTALLED_RST = CFG_W'(4096);
    localparam logic [CFG_W-1:0] RESERVED_RST  = CFG_W'(0);

    localparam logic [7:0] FULL_BYTE = 8'hFF;

    localparam logic [7:0] REG_INSTALLED = 8'd0;
    localparam logic [7:0] REG_RESERVED  = 8'd1;

    localparam logic STATUS_DONE     = 1'b0;
    localparam logic STATUS_NO_FRAME = 1'b1;

    typedef enum logic [1:0] {
        MODE_ALLOC = 2'd0,
        MODE_FREE  = 2'd1,
        MODE_INIT  = 2'd2
    } mode_t;

    function automatic logic [2:0] lowest_clear(input logic [7:0] b);
        logic [2:0] pos;
        pos = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (!b[i]) begin
                pos = 3'(i);
            end
        end
        return pos;
    endfunction

endpackage

`default_nettype wire

// File: src/pfba_ram.sv
// ----------------------------------------------------------------------------
// pfba_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module pfba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: src/page_frame_bitmap_allocator_top.sv
// ----------------------------------------------------------------------------
// page_frame_bitmap_allocator_top
// First-fit page frame allocator over a bitmap RAM, one bit per frame.
//
//   channel  direction  payload (low bit first)
//   s_       in         tdata: mode[1:0], phys_addr[25:2]
//   m_       out        tdata: frame_addr[23:0], status[24]
//   cfg_     in         index: register number, data[12:0]: register value
//
// One transaction at a time. Allocate scans the bitmap a byte at a time through the
// single RAM read port (up to MAX_PAGES/8 bytes); free reads the byte, clears the
// bit and writes it back; init makes one RAM write per byte.
// After reset a fill pass sets every byte to all used; s_tready stays low until it
// ends. A stalled m_ side holds the result; a new item is taken while it waits.
// ----------------------------------------------------------------------------
`default_nettype none

module page_frame_bitmap_allocator_top #(
    parameter int MAX_PAGES = pfba_pkg::MAX_PAGES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // mode[1:0], phys_addr[25:2]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // frame_addr[23:0], status[24]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int BB     = MAX_PAGES / 8;
    localparam int IDX_W  = (BB > 1) ? $clog2(BB) : 1;
    localparam int PAGE_W = IDX_W + 3;

    typedef enum logic [2:0] {
        ST_FILL,
        ST_IDLE,
        ST_ALLOC_CHK,
        ST_FREE_WR,
        ST_INIT,
        ST_RESP
    } state_t;

    state_t                           state_reg, state_next;
    logic [IDX_W-1:0]                 idx_reg, idx_next;
    logic [2:0]                       bit_reg, bit_next;
    logic                             free_ok_reg, free_ok_next;
    logic [pfba_pkg::ADDR_W-1:0]      res_frame_reg, res_frame_next;
    logic                             res_status_reg, res_status_next;
    logic                             m_valid_reg, m_valid_next;
    logic [pfba_pkg::ADDR_W-1:0]      m_frame_reg, m_frame_next;
    logic                             m_status_reg, m_status_next;
    logic [pfba_pkg::CFG_W-1:0]       installed_reg, installed_next;
    logic [pfba_pkg::CFG_W-1:0]       reserved_reg, reserved_next;

    logic                             ram_we;
    logic [IDX_W-1:0]                 ram_waddr;
    logic [7:0]                       ram_wdata;
    logic [IDX_W-1:0]                 ram_raddr;
    logic [7:0]                       ram_rdata;

    pfba_pkg::mode_t                  in_mode;
    logic [pfba_pkg::ADDR_W-1:0]      in_addr;
    logic [pfba_pkg::PFN_W-1:0]       free_pfn;
    logic [pfba_pkg::PFN_W-4:0]       free_byte;
    logic                             last_idx;
    logic                             out_free;
    logic [2:0]                       low_pos;
    logic [PAGE_W-1:0]                alloc_page;
    logic [PAGE_W+pfba_pkg::FRAME_SHIFT-1:0] alloc_full;
    logic [7:0]                       init_base;
    logic [7:0]                       init_res;

    pfba_ram #(
        .WIDTH (8),
        .DEPTH (BB)
    ) u_bitmap (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_mode    = pfba_pkg::mode_t'(s_tdata[1:0]);
    assign in_addr    = s_tdata[25:2];
    assign free_pfn   = in_addr[pfba_pkg::ADDR_W-1:pfba_pkg::FRAME_SHIFT];
    assign free_byte  = free_pfn[pfba_pkg::PFN_W-1:3];
    assign last_idx   = (32'(idx_reg) == 32'(BB - 1));
    assign out_free   = !m_valid_reg || m_tready;
    assign low_pos    = pfba_pkg::lowest_clear(ram_rdata);
    assign alloc_page = {idx_reg, low_pos};
    assign alloc_full = {alloc_page, {pfba_pkg::FRAME_SHIFT{1'b0}}};

    assign init_base = (32'(idx_reg) < 32'(installed_reg[pfba_pkg::CFG_W-1:3])) ?
                       8'h00 : pfba_pkg::FULL_BYTE;

    always_comb begin
        if (32'(idx_reg) < 32'(reserved_reg[pfba_pkg::CFG_W-1:3])) begin
            init_res = pfba_pkg::FULL_BYTE;
        end else if (32'(idx_reg) == 32'(reserved_reg[pfba_pkg::CFG_W-1:3])) begin
            init_res = 8'((9'd1 << reserved_reg[2:0]) - 9'd1);
        end else begin
            init_res = 8'h00;
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {7'd0, m_status_reg, m_frame_reg};

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        bit_next        = bit_reg;
        free_ok_next    = free_ok_reg;
        res_frame_next  = res_frame_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_frame_next    = m_frame_reg;
        m_status_next   = m_status_reg;
        installed_next  = installed_reg;
        reserved_next   = reserved_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = pfba_pkg::FULL_BYTE;
        ram_raddr       = idx_reg + IDX_W'(1);

        if (cfg_valid && cfg_ready) begin
            if (cfg_index == pfba_pkg::REG_INSTALLED) begin
                installed_next = cfg_data[pfba_pkg::CFG_W-1:0];
            end else if (cfg_index == pfba_pkg::REG_RESERVED) begin
                reserved_next = cfg_data[pfba_pkg::CFG_W-1:0];
            end
        end

        case (state_reg)
            ST_FILL: begin
                ram_we = 1'b1;
                if (last_idx) begin
                    state_next = ST_IDLE;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_IDLE: begin
                ram_raddr = (in_mode == pfba_pkg::MODE_FREE) ?
                            IDX_W'(free_byte) : IDX_W'(0);
                if (s_tvalid) begin
                    res_frame_next  = '0;
                    res_status_next = pfba_pkg::STATUS_DONE;
                    idx_next        = IDX_W'(0);
                    case (in_mode)
                        pfba_pkg::MODE_ALLOC: state_next = ST_ALLOC_CHK;
                        pfba_pkg::MODE_FREE: begin
                            idx_next     = IDX_W'(free_byte);
                            bit_next     = free_pfn[2:0];
                            free_ok_next = (32'(free_byte) < 32'(BB));
                            state_next   = ST_FREE_WR;
                        end
                        pfba_pkg::MODE_INIT:  state_next = ST_INIT;
                        default:              state_next = ST_RESP;
                    endcase
                end
            end
            ST_ALLOC_CHK: begin
                if (ram_rdata != pfba_pkg::FULL_BYTE) begin
                    ram_we         = 1'b1;
                    ram_wdata      = ram_rdata | 8'(1 << low_pos);
                    res_frame_next = pfba_pkg::ADDR_W'(alloc_full);
                    state_next     = ST_RESP;
                end else if (last_idx) begin
                    res_status_next = pfba_pkg::STATUS_NO_FRAME;
                    state_next      = ST_RESP;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_FREE_WR: begin
                ram_we     = free_ok_reg;
                ram_wdata  = ram_rdata & ~8'(1 << bit_reg);
                state_next = ST_RESP;
            end
            ST_INIT: begin
                ram_we    = 1'b1;
                ram_wdata = init_base | init_res;
                if (last_idx) begin
                    state_next = ST_RESP;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_frame_next  = res_frame_reg;
                    m_status_next = res_status_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_FILL;
            idx_reg       <= '0;
            m_valid_reg   <= 1'b0;
            installed_reg <= pfba_pkg::INSTALLED_RST;
            reserved_reg  <= pfba_pkg::RESERVED_RST;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            m_valid_reg   <= m_valid_next;
            installed_reg <= installed_next;
            reserved_reg  <= reserved_next;
        end
        bit_reg        <= bit_next;
        free_ok_reg    <= free_ok_next;
        res_frame_reg  <= res_frame_next;
        res_status_reg <= res_status_next;
        m_frame_reg    <= m_frame_next;
        m_status_reg   <= m_status_next;
    end

    a_no_accept_in_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FILL) |-> !s_tready)
        else $error("input taken during fill pass");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second transaction taken while busy");

    a_alloc_sets_one_bit: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && state_reg == ST_ALLOC_CHK) |-> $onehot(ram_wdata & ~ram_rdata))
        else $error("allocate write does not set exactly one clear bit");

    a_fail_frame_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[24]) |-> (m_tdata[23:0] == 24'd0))
        else $error("failed allocate returns nonzero frame");

    a_we_states: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_FILL || state_reg == ST_ALLOC_CHK ||
                    state_reg == ST_FREE_WR || state_reg == ST_INIT))
        else $error("bitmap write outside a writing state");

endmodule

`default_nettype wire

// File: dv/pfba_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfba_checker
// Watches the request, result and register channels of the page frame
// allocator. It keeps its own copy of the frame bitmap and of both registers.
// For every accepted request it computes the frame address and status that
// should come back, queues them, and compares each returned result with the
// oldest queued one.
// ----------------------------------------------------------------------------

module pfba_checker
    import pfba_pkg::*;
#(
    parameter int MAX_PAGES = MAX_PAGES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [31:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    output int               fail_count,
    output int               pending
);

    localparam int BITMAP_BYTES = MAX_PAGES / 8;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [ADDR_W-1:0] frame_addr;
        logic              status;
    } frame_result_t;

    logic [7:0]       used_map [BITMAP_BYTES];
    logic [CFG_W-1:0] installed_cnt;
    logic [CFG_W-1:0] reserved_cnt;
    frame_result_t    expected_frames [$];

    initial begin
        foreach (used_map[i]) begin
            used_map[i] = FULL_BYTE;
        end
        installed_cnt = INSTALLED_RST;
        reserved_cnt  = RESERVED_RST;
        fail_count    = 0;
        pending       = 0;
    end

    task automatic rebuild_map();
        int free_bytes;
        int limit;
        free_bytes = int'(installed_cnt) / 8;
        if (free_bytes > BITMAP_BYTES) begin
            free_bytes = BITMAP_BYTES;
        end
        for (int i = 0; i < BITMAP_BYTES; i++) begin
            used_map[i] = (i < free_bytes) ? 8'h00 : FULL_BYTE;
        end
        limit = int'(reserved_cnt);
        if (limit > MAX_PAGES) begin
            limit = MAX_PAGES;
        end
        for (int p = 0; p < limit; p++) begin
            if (p / 8 < BITMAP_BYTES) begin
                used_map[p / 8][p % 8] = 1'b1;
            end
        end
    endtask

    task automatic serve_request(input logic [1:0] md, input logic [ADDR_W-1:0] pa,
                                 output frame_result_t res);
        int  page;
        int  byte_idx;
        int  bit_idx;
        bit  found;
        res.frame_addr = '0;
        res.status     = STATUS_DONE;
        found          = 1'b0;
        page           = 0;
        if (md == MODE_ALLOC) begin
            for (byte_idx = 0; byte_idx < BITMAP_BYTES && !found; byte_idx++) begin
                if (used_map[byte_idx] != FULL_BYTE) begin
                    for (bit_idx = 0; bit_idx < 8 && !found; bit_idx++) begin
                        if (!used_map[byte_idx][bit_idx]) begin
                            page = byte_idx * 8 + bit_idx;
                            used_map[byte_idx][bit_idx] = 1'b1;
                            found = 1'b1;
                        end
                    end
                end
            end
            if (found) begin
                res.frame_addr = ADDR_W'(page * FRAME_BYTES);
            end else begin
                res.status = STATUS_NO_FRAME;
            end
        end else if (md == MODE_FREE) begin
            page = int'(pa >> FRAME_SHIFT);
            if (page < BITMAP_BYTES * 8) begin
                used_map[page / 8][page % 8] = 1'b0;
            end
        end else if (md == MODE_INIT) begin
            rebuild_map();
        end
    endtask

    always @(posedge aclk) begin : track
        frame_result_t due;
        frame_result_t seen;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                seen.frame_addr = m_tdata[ADDR_W-1:0];
                seen.status     = m_tdata[ADDR_W];
                if (expected_frames.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("%0t: result with nothing pending: frame_addr %h status %0d",
                                 $realtime, seen.frame_addr, seen.status);
                    end
                end else begin
                    due = expected_frames.pop_front();
                    if (seen.frame_addr != due.frame_addr || seen.status != due.status) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS) begin
                            $display("%0t: result mismatch: frame_addr exp %h got %h, status exp %0d got %0d",
                                     $realtime, due.frame_addr, seen.frame_addr,
                                     due.status, seen.status);
                        end
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_INSTALLED) begin
                    installed_cnt = cfg_data[CFG_W-1:0];
                end else if (cfg_index == REG_RESERVED) begin
                    reserved_cnt = cfg_data[CFG_W-1:0];
                end
            end
            if (s_tvalid && s_tready) begin
                serve_request(s_tdata[1:0], s_tdata[ADDR_W+1:2], due);
                expected_frames.push_back(due);
            end
            pending <= expected_frames.size();
        end
    end

endmodule

// File: dv/tb_page_frame_bitmap_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_page_frame_bitmap_allocator_top
// Stimulus and verdict for the page frame allocator. A directed part walks
// allocation from an all-used bitmap, exhaustion, freeing of used and free
// frames, saturated register values and the unused mode. Random phases then
// reprogram both registers, rebuild the bitmap and run allocate/free mixes
// with frees aimed at frames handed out earlier. Both sides idle in bursts;
// one phase holds the result side off long enough to back the block up.
// ----------------------------------------------------------------------------

module tb_page_frame_bitmap_allocator_top;
    import pfba_pkg::*;

    localparam logic [1:0] MODE_UNUSED    = 2'd3;
    localparam int         TOTAL_ITEMS    = 1050;
    localparam int         QUIET_TAIL     = 120;
    localparam int         HOLD_CYCLES    = 600;
    localparam int         SETTLE_CYCLES  = 600;
    localparam int         WATCHDOG_LIMIT = 10000;
    localparam int         PAGE_MAX       = MAX_PAGES_DEF - 1;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    int fail_count;
    int pending;
    int sent_items = 0;
    bit quiet      = 1'b0;
    bit hold_req   = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    page_frame_bitmap_allocator_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pfba_checker i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    task automatic send_request(input logic [1:0] md, input logic [ADDR_W-1:0] pa);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, pa, md};
        do @(posedge aclk); while (!s_tready);
        sent_items++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    task automatic write_regs(input logic [CFG_W-1:0] installed, input logic [CFG_W-1:0] reserved);
        cfg_valid <= 1'b1;
        cfg_index <= REG_INSTALLED;
        cfg_data  <= 16'(installed);
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= REG_RESERVED;
        cfg_data  <= 16'(reserved);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int n_items, input int reserved);
        int granted;
        int window;
        int r;
        granted = 0;
        send_request(MODE_INIT, ADDR_W'($urandom));
        for (int i = 1; i < n_items; i++) begin
            r = $urandom_range(0, 99);
            window = (reserved > MAX_PAGES_DEF ? MAX_PAGES_DEF : reserved) + granted + 8;
            if (window > PAGE_MAX) begin
                window = PAGE_MAX;
            end
            if (r < 55) begin
                send_request(MODE_ALLOC, ADDR_W'($urandom));
                granted++;
            end else if (r < 85) begin
                send_request(MODE_FREE, {12'($urandom_range(0, window)), 12'($urandom)});
            end else if (r < 92) begin
                send_request(MODE_FREE, ADDR_W'($urandom));
            end else if (r < 97) begin
                send_request(MODE_UNUSED, ADDR_W'($urandom));
            end else begin
                send_request(MODE_INIT, ADDR_W'($urandom));
                granted = 0;
            end
        end
    endtask

    initial begin : result_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                m_tready   <= 1'b0;
                stall_left = $urandom_range(1, 9) - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stimulus
        int phase_no;
        int sel;
        int installed;
        int reserved;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // bitmap is all used out of reset
        send_request(MODE_ALLOC, ADDR_W'($urandom));
        send_request(MODE_INIT, ADDR_W'($urandom));
        send_request(MODE_ALLOC, 24'h000000);
        send_request(MODE_ALLOC, 24'hFFFFFF);
        send_request(MODE_FREE, 24'h000FFF);
        send_request(MODE_ALLOC, 24'h000000);
        send_request(MODE_FREE, 24'hFFFFFF);
        send_request(MODE_FREE, 24'hFFFFFF);
        send_request(MODE_UNUSED, 24'h5A5A5A);
        send_request(MODE_FREE, 24'hABCDEF);

        // partial byte of installed pages, reserved frames, then exhaustion
        drain_results();
        write_regs(CFG_W'(13), CFG_W'(3));
        send_request(MODE_INIT, 24'h000000);
        repeat (6) send_request(MODE_ALLOC, ADDR_W'($urandom));

        // both registers beyond capacity
        drain_results();
        write_regs(CFG_W'(8191), CFG_W'(8191));
        send_request(MODE_INIT, 24'hFFFFFF);
        send_request(MODE_ALLOC, 24'h000000);

        drain_results();
        write_regs(CFG_W'(0), CFG_W'(0));
        send_request(MODE_INIT, 24'h000000);
        send_request(MODE_FREE, 24'h005000);
        send_request(MODE_ALLOC, 24'h000000);
        send_request(MODE_ALLOC, 24'h000000);

        drain_results();
        write_regs(CFG_W'(8191), CFG_W'(0));
        send_request(MODE_INIT, 24'h000000);
        send_request(MODE_ALLOC, 24'h000000);

        phase_no = 0;
        while (sent_items < TOTAL_ITEMS) begin
            drain_results();
            quiet = (sent_items > TOTAL_ITEMS - QUIET_TAIL) || ($urandom_range(0, 3) == 0);
            sel = $urandom_range(0, 9);
            if (sel == 0) begin
                installed = $urandom_range(0, 8191);
                reserved  = $urandom_range(0, 8191);
            end else if (sel == 1) begin
                installed = MAX_PAGES_DEF;
                reserved  = $urandom_range(PAGE_MAX, MAX_PAGES_DEF);
            end else begin
                installed = $urandom_range(0, 320);
                reserved  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, installed / 2);
            end
            write_regs(CFG_W'(installed), CFG_W'(reserved));
            if (phase_no == 2) begin
                quiet    = 1'b0;
                hold_req = 1'b1;
            end
            run_phase($urandom_range(15, 50), reserved);
            phase_no++;
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/pfba_pkg.sv
src/pfba_ram.sv
src/page_frame_bitmap_allocator_top.sv
dv/pfba_checker.sv
dv/tb_page_frame_bitmap_allocator_top.sv
